### rtl/cstretch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstretch_pkg
// Shared widths, register indexes, reset values and types for the contrast
// stretch unit.
// ----------------------------------------------------------------------------
package cstretch_pkg;

    // Pixel and arithmetic widths
    localparam int PIX_W   = 8;
    localparam int NUM_W   = 17;   // 2*(p-min)*255 + range stays below 2**17
    localparam int DEN_W   = 9;    // 2*range
    localparam int QUOT_W  = 8;    // quotient never exceeds 255
    localparam int DSH_W   = DEN_W + QUOT_W - 1;
    localparam int CNT_W   = $clog2(QUOT_W);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd2;

    // Reset values
    localparam logic             SLICE_MODE_RST  = 1'b0;
    localparam logic [PIX_W-1:0] WINDOW_LOW_RST  = 8'd50;
    localparam logic [PIX_W-1:0] WINDOW_HIGH_RST = 8'd81;
    localparam logic [PIX_W-1:0] MIN_SEEN_RST    = 8'd255;
    localparam logic [PIX_W-1:0] MAX_SEEN_RST    = 8'd0;

    // Full-scale output value
    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

    // Divider status back to the sequencer
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

endpackage

### rtl/cstretch_minmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstretch_minmax
// Tracks the smallest and largest pixel of the scan pass.
// ----------------------------------------------------------------------------
module cstretch_minmax
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            upd,
    input  logic                            frame_start,
    input  logic [cstretch_pkg::PIX_W-1:0]  pixel,
    output logic [cstretch_pkg::PIX_W-1:0]  min_seen,
    output logic [cstretch_pkg::PIX_W-1:0]  max_seen
);
    import cstretch_pkg::*;

    logic [PIX_W-1:0] min_seen_reg;
    logic [PIX_W-1:0] min_seen_next;
    logic [PIX_W-1:0] max_seen_reg;
    logic [PIX_W-1:0] max_seen_next;

    // A frame start reloads both bounds; other scan pixels widen them.
    always_comb
    begin
        min_seen_next = min_seen_reg;
        max_seen_next = max_seen_reg;
        if (upd)
        begin
            if (frame_start)
            begin
                min_seen_next = pixel;
                max_seen_next = pixel;
            end
            else
            begin
                if (pixel < min_seen_reg)
                begin
                    min_seen_next = pixel;
                end
                if (pixel > max_seen_reg)
                begin
                    max_seen_next = pixel;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_seen_reg <= MIN_SEEN_RST;
            max_seen_reg <= MAX_SEEN_RST;
        end
        else
        begin
            min_seen_reg <= min_seen_next;
            max_seen_reg <= max_seen_next;
        end
    end

    assign min_seen = min_seen_reg;
    assign max_seen = max_seen_reg;

    // After any scan update the bounds enclose at least one pixel.
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (min_seen_reg <= max_seen_reg))
        else $error("min_seen above max_seen after a scan update");

endmodule

### rtl/cstretch_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstretch_div
// Restoring divider: one trial subtraction per cycle, one quotient bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module cstretch_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [cstretch_pkg::NUM_W-1:0]   num,
    input  logic [cstretch_pkg::DEN_W-1:0]   den,
    output cstretch_pkg::div_stat_t          stat
);
    import cstretch_pkg::*;

    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NUM_W:0]    trial;

    // Trial subtraction of the shifted divisor from the partial remainder.
    assign trial = {1'b0, rem_reg} - {{(NUM_W + 1 - DSH_W){1'b0}}, dsh_reg};

    // Control: busy while the quotient bits are formed, done pulses for one cycle after.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: remainder, shifting divisor and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsh_reg  <= {den, {(QUOT_W - 1){1'b0}}};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[NUM_W])
            begin
                rem_reg <= trial[NUM_W-1:0];
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], ~trial[NUM_W]};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

    // A new division never starts while one is still running.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

    // Done rises in the cycle after the last step.
    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (cnt_reg == '0)) |=> (done_reg && !busy_reg))
        else $error("divider done pulse out of step");

endmodule

### rtl/contrast_stretch_with_slicing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_stretch_with_slicing_unit
// Min-max contrast stretch of 8-bit grey pixels with optional intensity
// slicing, using one shared restoring divider.
// ----------------------------------------------------------------------------
// Each frame is streamed twice. A scan-pass pixel (s_tuser bit 0 low) is taken,
// updates the tracked minimum and maximum and gives no output, so scan pixels
// flow at one per cycle while no map pixel is in progress. A map-pass pixel
// gives one output, round((p - min) * 255 / (max - min)) rounded half up, or
// the tracked minimum when slicing is on and the pixel lies outside the window.
// A map pixel that needs the division holds s_tready low through a setup
// state, a divide state that runs the shared restoring subtractor (one
// quotient bit per step) and collects the quotient, and a done state that
// loads the output register. Pixels that map to a fixed value (outside the
// window, at or beyond the bounds, or an empty range) go from setup to done.
// The output register lets the next pixel be taken while a result still waits.
// ----------------------------------------------------------------------------
module contrast_stretch_with_slicing_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [cstretch_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
    input  logic [1:0]                           s_tuser,   // [0] map_pass, [1] frame_start
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cstretch_pkg::PIX_W-1:0]       m_tdata,   // [7:0] stretched
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [cstretch_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cstretch_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cstretch_pkg::*;

    // Sequencer state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              slice_mode_reg;
    logic [PIX_W-1:0]  window_low_reg;
    logic [PIX_W-1:0]  window_high_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  res_reg;
    logic [PIX_W-1:0]  res_next;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_data_reg;

    logic              in_xfer;
    logic              out_free;
    logic              scan_upd;
    logic [PIX_W-1:0]  min_seen;
    logic [PIX_W-1:0]  max_seen;
    logic              in_window;
    logic [PIX_W-1:0]  diff;
    logic [PIX_W-1:0]  range;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_start;
    div_stat_t         div_stat;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign scan_upd = in_xfer && !s_tuser[0];
    assign s_tready = (state_reg == ST_IDLE);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_mode_reg  <= SLICE_MODE_RST;
            window_low_reg  <= WINDOW_LOW_RST;
            window_high_reg <= WINDOW_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLICE_MODE:  slice_mode_reg  <= cfg_data[0];
                REG_WINDOW_LOW:  window_low_reg  <= cfg_data[PIX_W-1:0];
                REG_WINDOW_HIGH: window_high_reg <= cfg_data[PIX_W-1:0];
                default:         ;
            endcase
        end
    end

    // Scan-pass bound tracking
    cstretch_minmax u_minmax
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (scan_upd),
        .frame_start (s_tuser[1]),
        .pixel       (s_tdata),
        .min_seen    (min_seen),
        .max_seen    (max_seen)
    );

    // Divider operands: num = 510*(p-min) + range, den = 2*range.
    assign in_window = (pix_reg >= window_low_reg) && (pix_reg <= window_high_reg);
    assign diff      = pix_reg - min_seen;
    assign range     = max_seen - min_seen;
    assign div_num   = {diff, {(NUM_W - PIX_W){1'b0}}}
                     - {{(NUM_W - PIX_W - 1){1'b0}}, diff, 1'b0}
                     + {{(NUM_W - PIX_W){1'b0}}, range};
    assign div_den   = {range, 1'b0};

    cstretch_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat)
    );

    // Sequencer: settle fixed cases in setup, otherwise run the divider.
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && s_tuser[0])
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DONE;
                if (slice_mode_reg && !in_window)
                begin
                    res_next = min_seen;
                end
                else if ((max_seen <= min_seen) || (pix_reg <= min_seen))
                begin
                    res_next = '0;
                end
                else if (pix_reg >= max_seen)
                begin
                    res_next = PIX_FULL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next   = div_stat.quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pixel and result holding registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pix_reg <= s_tdata;
        end
        res_reg <= res_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The divider reports completion only while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider done outside the divide state");

    // A map-pass transfer always enters setup next.
    a_map_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tuser[0]) |=> (state_reg == ST_PREP))
        else $error("map pixel did not enter setup");

    // A finished result waits while the output register is still occupied.
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_valid_reg && !m_tready)
            |=> (state_reg == ST_DONE))
        else $error("result left the done state while the output was blocked");

endmodule
